### rtl/jrbs_pkg.sv
`timescale 1ns / 1ps

package jrbs_pkg;

  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam int unsigned LinesOutBits = 16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_start;
    logic       buffer_last;
  } jrbs_item_t;

  typedef struct packed {
    logic                    ends_after;
    logic                    ends_before;
    logic [LinesOutBits-1:0] lines_in_record;
    logic                    incomplete;
    logic                    depth_overflow;
  } jrbs_res_t;

endpackage

### rtl/jrbs_in_if.sv
`timescale 1ns / 1ps

interface jrbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       record_start;
  logic       buffer_last;

  modport source (output valid, output data_byte, output record_start, output buffer_last,
                  input ready);
  modport sink (input valid, input data_byte, input record_start, input buffer_last,
                output ready);
endinterface

### rtl/jrbs_out_if.sv
`timescale 1ns / 1ps

interface jrbs_out_if;
  logic        valid;
  logic        ready;
  logic        ends_after;
  logic        ends_before;
  logic [15:0] lines_in_record;
  logic        incomplete;
  logic        depth_overflow;

  modport source (output valid, output ends_after, output ends_before,
                  output lines_in_record, output incomplete, output depth_overflow,
                  input ready);
  modport sink (input valid, input ends_after, input ends_before,
                input lines_in_record, input incomplete, input depth_overflow,
                output ready);
endinterface

### rtl/jrbs_scan_core.sv
`timescale 1ns / 1ps

module jrbs_scan_core #(
  parameter int unsigned DEPTH_BITS = 16,
  parameter int unsigned LINE_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  jrbs_pkg::jrbs_item_t item_i,
  output jrbs_pkg::jrbs_res_t  res_o
);
  import jrbs_pkg::*;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_NESTED = 2'd1;
  localparam logic [1:0] MODE_PRIM   = 2'd2;

  logic [1:0]            mode_q, mode_d;
  logic                  str_q, str_d;
  logic                  esc_q, esc_d;
  logic [DEPTH_BITS-1:0] depth_q, depth_d;
  logic [LINE_BITS-1:0]  lines_q, lines_d;
  logic [31:0]           lines_ext;
  logic                  after, prim_end, ovf;
  logic [7:0]            b;

  assign b = item_i.data_byte;

  always_comb begin
    mode_d   = mode_q;
    str_d    = str_q;
    esc_d    = esc_q;
    depth_d  = depth_q;
    lines_d  = lines_q;
    after    = 1'b0;
    prim_end = 1'b0;
    ovf      = 1'b0;
    res_o    = '0;

    if (item_i.record_start) begin
      mode_d  = (b inside {CH_LBRACE, CH_LBRACK, CH_QUOTE}) ? MODE_NESTED : MODE_PRIM;
      str_d   = 1'b0;
      esc_d   = 1'b0;
      depth_d = '0;
      lines_d = '0;
    end

    if (mode_d != MODE_IDLE) begin
      if (mode_d == MODE_PRIM) begin
        if (b inside {CH_COMMA, CH_RBRACK}) begin
          prim_end = 1'b1;
        end else if (b == CH_NEWLINE && lines_d != '1) begin
          lines_d = lines_d + 1'b1;
        end
      end else if (str_d) begin
        if (esc_d) begin
          esc_d = 1'b0;
        end else if (b == CH_QUOTE) begin
          str_d = 1'b0;
          after = (depth_d == '0);
        end else if (b == CH_BSLASH) begin
          esc_d = 1'b1;
        end else if (b == CH_NEWLINE && lines_d != '1) begin
          lines_d = lines_d + 1'b1;
        end
      end else begin
        if (b inside {CH_LBRACE, CH_LBRACK}) begin
          if (depth_d == '1) begin
            ovf = 1'b1;
          end else begin
            depth_d = depth_d + 1'b1;
          end
        end else if (b inside {CH_RBRACE, CH_RBRACK}) begin
          if (depth_d != '0) begin
            depth_d = depth_d - 1'b1;
          end
          after = (depth_d == '0);
        end else if (b == CH_QUOTE) begin
          str_d = 1'b1;
        end else if (b == CH_NEWLINE && lines_d != '1) begin
          lines_d = lines_d + 1'b1;
        end
      end

      lines_ext             = 32'(lines_d);
      res_o.lines_in_record = lines_ext[LinesOutBits-1:0];
      res_o.depth_overflow  = ovf;

      if (prim_end) begin
        res_o.ends_before = 1'b1;
      end else if (after) begin
        res_o.incomplete = item_i.buffer_last;
        res_o.ends_after = !item_i.buffer_last;
      end else begin
        res_o.incomplete = item_i.buffer_last;
      end

      if (prim_end || after || item_i.buffer_last) begin
        mode_d  = MODE_IDLE;
        str_d   = 1'b0;
        esc_d   = 1'b0;
        depth_d = '0;
      end
    end else begin
      lines_ext = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      str_q   <= 1'b0;
      esc_q   <= 1'b0;
      depth_q <= '0;
      lines_q <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      str_q   <= str_d;
      esc_q   <= esc_d;
      depth_q <= depth_d;
      lines_q <= lines_d;
    end
  end

endmodule

### rtl/json_record_boundary_scanner_top.sv
`timescale 1ns / 1ps
// A byte accepted into the input register has its result computed by the scan
// core and captured in the output register once that register can load.
// Throughput: one byte per cycle while the output is not stalled; the per-byte
// state update in the scan core is the only recurrence and is combinational.
// Reset (rst_ni, async, active low): pipeline empty, scanner idle, depth and
// line count cleared.

module json_record_boundary_scanner_top #(
  parameter int unsigned DEPTH_BITS = 16,
  parameter int unsigned LINE_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  jrbs_in_if.sink           in_i,
  jrbs_out_if.source        out_o
);
  import jrbs_pkg::*;

  logic       in_valid_q;
  jrbs_item_t in_item_q;
  logic       out_valid_q;
  jrbs_res_t  out_res_q;
  jrbs_res_t  core_res;
  logic       out_load;
  logic       advance;

  assign out_load   = !out_valid_q || out_o.ready;
  assign advance    = in_valid_q && out_load;
  assign in_i.ready = !in_valid_q || out_load;

  jrbs_scan_core #(
    .DEPTH_BITS(DEPTH_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .item_i(in_item_q),
    .res_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q.data_byte    <= in_i.data_byte;
      in_item_q.record_start <= in_i.record_start;
      in_item_q.buffer_last  <= in_i.buffer_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.ends_after      = out_res_q.ends_after;
  assign out_o.ends_before     = out_res_q.ends_before;
  assign out_o.lines_in_record = out_res_q.lines_in_record;
  assign out_o.incomplete      = out_res_q.incomplete;
  assign out_o.depth_overflow  = out_res_q.depth_overflow;

  a_end_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_res_q.ends_after && out_res_q.ends_before))
    else $error("ends_after and ends_before both set");

  a_incomplete_no_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_res_q.incomplete && out_res_q.ends_after))
    else $error("incomplete reported with ends_after");

  a_held_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_load) |=> in_valid_q)
    else $error("input stage dropped a transaction under backpressure");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed transaction did not reach the output register");

endmodule

### tb/jrbs_boundary_checker.sv
`timescale 1ns / 1ps

module jrbs_boundary_checker #(
  parameter int unsigned DEPTH_BITS = 16,
  parameter int unsigned LINE_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  jrbs_in_if          in_i,
  jrbs_out_if         res_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned boundaries_o
);
  import jrbs_pkg::*;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_NESTED,
    SCAN_PRIM
  } scan_mode_e;

  scan_mode_e            mode;
  logic                  in_str;
  logic                  esc;
  logic [DEPTH_BITS-1:0] depth;
  logic [LINE_BITS-1:0]  line_cnt;

  jrbs_res_t   expected_q[$];
  int unsigned err_cnt;
  int unsigned bound_cnt;

  task automatic report(input string msg);
    err_cnt++;
    if (err_cnt <= 100) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
  endtask

  task automatic go_idle();
    mode   = SCAN_IDLE;
    in_str = 1'b0;
    esc    = 1'b0;
    depth  = '0;
  endtask

  task automatic scan_byte(input jrbs_item_t it, output jrbs_res_t res);
    logic [7:0] b;
    logic       closes;
    logic       prim_end;
    logic       ovf;
    b        = it.data_byte;
    closes   = 1'b0;
    prim_end = 1'b0;
    ovf      = 1'b0;
    res      = '0;
    if (it.record_start) begin
      go_idle();
      line_cnt = '0;
      mode = (b == CH_LBRACE || b == CH_LBRACK || b == CH_QUOTE) ? SCAN_NESTED : SCAN_PRIM;
    end
    if (mode == SCAN_IDLE) return;

    if (mode == SCAN_PRIM) begin
      if (b == CH_COMMA || b == CH_RBRACK) prim_end = 1'b1;
      else if (b == CH_NEWLINE && line_cnt != '1) line_cnt++;
    end else if (in_str) begin
      if (esc) begin
        esc = 1'b0;
      end else if (b == CH_QUOTE) begin
        in_str = 1'b0;
        if (depth == '0) closes = 1'b1;
      end else if (b == CH_BSLASH) begin
        esc = 1'b1;
      end else if (b == CH_NEWLINE && line_cnt != '1) begin
        line_cnt++;
      end
    end else begin
      if (b == CH_LBRACE || b == CH_LBRACK) begin
        if (depth == '1) ovf = 1'b1;
        else depth++;
      end else if (b == CH_RBRACE || b == CH_RBRACK) begin
        if (depth != '0) depth--;
        if (depth == '0) closes = 1'b1;
      end else if (b == CH_QUOTE) begin
        in_str = 1'b1;
      end else if (b == CH_NEWLINE && line_cnt != '1) begin
        line_cnt++;
      end
    end

    res.lines_in_record = LinesOutBits'(line_cnt);
    res.depth_overflow  = ovf;
    if (prim_end) begin
      res.ends_before = 1'b1;
      go_idle();
    end else if (closes) begin
      if (it.buffer_last) res.incomplete = 1'b1;
      else res.ends_after = 1'b1;
      go_idle();
    end else if (it.buffer_last) begin
      res.incomplete = 1'b1;
      go_idle();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    jrbs_res_t  exp_r;
    jrbs_res_t  next_r;
    jrbs_item_t it;
    if (!rst_ni) begin
      go_idle();
      line_cnt = '0;
      expected_q.delete();
      err_cnt   = 0;
      bound_cnt = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (expected_q.size() == 0) begin
          report("result transaction with nothing expected");
        end else begin
          exp_r = expected_q.pop_front();
          if (res_i.ends_after !== exp_r.ends_after)
            report($sformatf("ends_after got %b exp %b", res_i.ends_after, exp_r.ends_after));
          if (res_i.ends_before !== exp_r.ends_before)
            report($sformatf("ends_before got %b exp %b", res_i.ends_before,
                             exp_r.ends_before));
          if (res_i.lines_in_record !== exp_r.lines_in_record)
            report($sformatf("lines_in_record got %0d exp %0d", res_i.lines_in_record,
                             exp_r.lines_in_record));
          if (res_i.incomplete !== exp_r.incomplete)
            report($sformatf("incomplete got %b exp %b", res_i.incomplete, exp_r.incomplete));
          if (res_i.depth_overflow !== exp_r.depth_overflow)
            report($sformatf("depth_overflow got %b exp %b", res_i.depth_overflow,
                             exp_r.depth_overflow));
        end
      end
      if (in_i.valid && in_i.ready) begin
        it.data_byte    = in_i.data_byte;
        it.record_start = in_i.record_start;
        it.buffer_last  = in_i.buffer_last;
        scan_byte(it, next_r);
        if (next_r.ends_after || next_r.ends_before || next_r.incomplete) bound_cnt++;
        expected_q = {expected_q, next_r};
      end
    end
    errors_o     <= err_cnt;
    pending_o    <= expected_q.size();
    boundaries_o <= bound_cnt;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import jrbs_pkg::*;

  localparam int unsigned DepthBits   = 16;
  localparam int unsigned LineBits    = 16;
  localparam int unsigned RandomBytes = 1100;

  logic clk;
  logic rst_n;
  logic gaps_on;

  jrbs_in_if  byte_if ();
  jrbs_out_if res_if ();

  int unsigned n_errors;
  int unsigned n_pending;
  int unsigned n_boundaries;
  int unsigned n_sent;
  int unsigned record_bytes;

  logic [7:0] rec_q[$];

  json_record_boundary_scanner_top #(
    .DEPTH_BITS(DepthBits),
    .LINE_BITS (LineBits)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (byte_if),
    .out_o (res_if)
  );

  jrbs_boundary_checker #(
    .DEPTH_BITS(DepthBits),
    .LINE_BITS (LineBits)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (byte_if),
    .res_i       (res_if),
    .errors_o    (n_errors),
    .pending_o   (n_pending),
    .boundaries_o(n_boundaries)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    res_if.ready <= rst_n && (!gaps_on || ($urandom_range(0, 99) >= 10));
  end

  task automatic add_byte(input logic [7:0] b);
    rec_q = {rec_q, b};
  endtask

  task automatic send_byte(input logic [7:0] b, input logic start, input logic last);
    while (gaps_on && $urandom_range(0, 99) < 10) begin
      byte_if.valid <= 1'b0;
      @(posedge clk);
    end
    byte_if.valid        <= 1'b1;
    byte_if.data_byte    <= b;
    byte_if.record_start <= start;
    byte_if.buffer_last  <= last;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic add_filler(input bit allow_comma);
    int unsigned r;
    logic [7:0]  b;
    r = $urandom_range(0, 99);
    if (r < 3) b = 8'($urandom_range(0, 255));
    else if (r < 15) b = CH_NEWLINE;
    else if (r < 22 && allow_comma) b = CH_COMMA;
    else if (r < 30) b = 8'h3A;
    else begin
      b = 8'($urandom_range(8'h30, 8'h7A));
      if (b == CH_LBRACK || b == CH_RBRACK || b == CH_BSLASH) b = 8'h61;
    end
    add_byte(b);
  endtask

  task automatic add_string();
    int unsigned n;
    add_byte(CH_QUOTE);
    n = $urandom_range(0, 10);
    repeat (n) begin
      if ($urandom_range(0, 99) < 15) begin
        add_byte(CH_BSLASH);
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        add_filler(1'b1);
        if (rec_q[$] == CH_QUOTE || rec_q[$] == CH_BSLASH) rec_q[$] = 8'h7A;
      end
    end
    add_byte(CH_QUOTE);
  endtask

  task automatic build_nested();
    logic [7:0]  closers[$];
    int unsigned steps;
    int unsigned r;
    r = $urandom_range(0, 2);
    if (r == 2) begin
      add_string();
      return;
    end
    add_byte(r == 0 ? CH_LBRACE : CH_LBRACK);
    closers = {closers, (r == 0 ? CH_RBRACE : CH_RBRACK)};
    steps = $urandom_range(0, 20);
    repeat (steps) begin
      r = $urandom_range(0, 99);
      if (r < 20 && closers.size() < 8) begin
        if ($urandom_range(0, 1)) begin
          add_byte(CH_LBRACE);
          closers = {closers, CH_RBRACE};
        end else begin
          add_byte(CH_LBRACK);
          closers = {closers, CH_RBRACK};
        end
      end else if (r < 35 && closers.size() > 1) begin
        add_byte(closers.pop_back());
      end else if (r < 55) begin
        add_string();
      end else begin
        add_filler(1'b1);
      end
    end
    while (closers.size() != 0) add_byte(closers.pop_back());
  endtask

  task automatic build_prim();
    logic [7:0]  b;
    int unsigned steps;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_LBRACE || b == CH_LBRACK || b == CH_QUOTE);
    add_byte(b);
    steps = $urandom_range(0, 8);
    repeat (steps) add_filler(1'b0);
    add_byte($urandom_range(0, 1) ? CH_COMMA : CH_RBRACK);
  endtask

  task automatic send_record(input int last_at, input int stop_at);
    for (int i = 0; i < stop_at; i++) begin
      send_byte(rec_q[i], i == 0, i == last_at);
    end
    record_bytes += stop_at;
  endtask

  initial begin : stimulus
    int unsigned r;
    int          len;
    int          cut;
    bit          paused;
    gaps_on              = 1'b1;
    paused               = 1'b0;
    n_sent               = 0;
    record_bytes         = 0;
    byte_if.valid        = 1'b0;
    byte_if.data_byte    = '0;
    byte_if.record_start = 1'b0;
    byte_if.buffer_last  = 1'b0;
    rst_n                = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle bytes, ignored
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    // primitive with a newline
    send_byte(8'h31, 1'b1, 1'b0);
    send_byte(CH_NEWLINE, 1'b0, 1'b0);
    send_byte(CH_COMMA, 1'b0, 1'b0);
    // empty primitives
    send_byte(CH_COMMA, 1'b1, 1'b0);
    send_byte(CH_RBRACK, 1'b1, 1'b0);
    // escaped newline inside a string is skipped
    send_byte(CH_LBRACE, 1'b1, 1'b0);
    send_byte(CH_QUOTE, 1'b0, 1'b0);
    send_byte(CH_BSLASH, 1'b0, 1'b0);
    send_byte(CH_NEWLINE, 1'b0, 1'b0);
    send_byte(CH_QUOTE, 1'b0, 1'b0);
    send_byte(CH_NEWLINE, 1'b0, 1'b0);
    send_byte(CH_RBRACE, 1'b0, 1'b0);
    // top-level string
    send_byte(CH_QUOTE, 1'b1, 1'b0);
    send_byte(8'h61, 1'b0, 1'b0);
    send_byte(CH_QUOTE, 1'b0, 1'b0);
    // close on the last byte of the buffer
    send_byte(CH_LBRACK, 1'b1, 1'b0);
    send_byte(CH_RBRACK, 1'b0, 1'b1);
    // buffer ends mid-record
    send_byte(CH_LBRACE, 1'b1, 1'b0);
    send_byte(8'h61, 1'b0, 1'b1);
    // primitive ends on the last byte
    send_byte(8'h78, 1'b1, 1'b0);
    send_byte(CH_COMMA, 1'b0, 1'b1);
    // restart mid-record
    send_byte(CH_LBRACE, 1'b1, 1'b0);
    send_byte(8'h37, 1'b1, 1'b0);
    send_byte(CH_RBRACK, 1'b0, 1'b0);

    // deeper nesting with newlines, cut off by the buffer end
    send_byte(CH_LBRACK, 1'b1, 1'b0);
    repeat (12) send_byte(CH_LBRACK, 1'b0, 1'b0);
    repeat (5) send_byte(CH_NEWLINE, 1'b0, 1'b0);
    send_byte(CH_RBRACK, 1'b0, 1'b0);
    send_byte(CH_RBRACE, 1'b0, 1'b1);

    while (record_bytes < RandomBytes) begin
      gaps_on = !(record_bytes >= 400 && record_bytes < 650);
      if (!paused && record_bytes >= 800) begin
        paused = 1'b1;
        byte_if.valid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 3)) begin
          send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        end
      end else begin
        rec_q.delete();
        if (r < 60) build_nested();
        else build_prim();
        len = rec_q.size();
        r = $urandom_range(0, 99);
        if (r < 70) begin
          send_record(-1, len);
        end else if (r < 80) begin
          send_record(len - 1, len);
        end else if (r < 90) begin
          cut = int'($urandom_range(0, len - 1));
          send_record(cut, cut + 1);
        end else begin
          cut = int'($urandom_range(1, len));
          send_record(-1, cut);
        end
      end
    end
    gaps_on = 1'b1;
    byte_if.valid <= 1'b0;

    while (n_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes: directed cases, a deep nesting run cut by the buffer end,",
             n_sent);
    $display("and random records; %0d boundaries or truncations seen",
             n_boundaries);
    if (n_errors == 0 && n_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("Timeout waiting for transactions");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
